FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the text extractor blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define HTE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define HTE_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `HTE_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

FILE: design/hte_pkg.sv
// ----------------------------------------------------------------------------
// hte_pkg
// Types and character codes shared by the text extractor modules.
// ----------------------------------------------------------------------------
package hte_pkg;

    // Default depth of the event queue between front and back
    localparam int FIFO_DEPTH = 4;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // One queue entry: a raw text word, or the end-of-document marker;
    // from_last tags entries made while handling the final word of a document
    typedef struct packed {
        logic [7:0] data;
        logic       is_end;
        logic       from_last;
    } t_evt;

endpackage

FILE: design/hte_front.sv
// ----------------------------------------------------------------------------
// hte_front
// Accepts HTML words, tracks tag/script/style state and entity matching, and
// pushes raw text words plus an end-of-document marker into the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hte_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_in_byte,
    input  logic              i_in_last,
    output logic              o_push,
    output hte_pkg::t_evt     o_evt,
    input  logic              i_full
);

    localparam int WIN_DEPTH  = 9;
    localparam int HOLD_DEPTH = 5;
    localparam int NUM_ENT    = 5;
    localparam int CAND_LEN   = HOLD_DEPTH + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_FLUSH  = 3'd2;
    localparam logic [2:0] ST_NORM   = 3'd3;
    localparam logic [2:0] ST_END    = 3'd4;
    localparam logic [2:0] ST_LFLUSH = 3'd5;

    localparam logic [63:0] CLOSE_SCRIPT_LC = "</script";
    localparam logic [63:0] CLOSE_SCRIPT_UC = "</SCRIPT";
    localparam logic [55:0] CLOSE_STYLE_LC  = "</style";
    localparam logic [55:0] CLOSE_STYLE_UC  = "</STYLE";
    localparam logic [47:0] OPEN_SCRIP_LC   = "<scrip";
    localparam logic [47:0] OPEN_SCRIP_UC   = "<SCRIP";
    localparam logic [39:0] OPEN_STYL_LC    = "<styl";
    localparam logic [39:0] OPEN_STYL_UC    = "<STYL";
    localparam logic [7:0]  CH_T_LC         = "t";
    localparam logic [7:0]  CH_T_UC         = "T";
    localparam logic [7:0]  CH_E_LC         = "e";
    localparam logic [7:0]  CH_E_UC         = "E";

    localparam logic [3:0] CLOSE_SCRIPT_LEN = 4'd8;
    localparam logic [3:0] CLOSE_STYLE_LEN  = 4'd7;
    localparam logic [3:0] OPEN_SCRIP_LEN   = 4'd6;
    localparam logic [3:0] OPEN_STYL_LEN    = 4'd5;
    localparam logic [3:0] WIN_FULL         = 4'(WIN_DEPTH);

    // Entity texts, left aligned, zero padded to six characters
    localparam logic [47:0] ENT_TXT [NUM_ENT] = '{
        {"&amp;", 8'h00}, {"&lt;", 16'h0000}, {"&gt;", 16'h0000},
        "&quot;", {"&#39;", 8'h00}
    };
    localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd5};
    localparam logic [7:0] ENT_DEC [NUM_ENT] = '{"&", "<", ">", "\"", "'"};

    logic [2:0] r_state, n_state;
    logic       r_in_tag, n_in_tag;
    logic       r_scr_body, n_scr_body;
    logic       r_sty_body, n_sty_body;
    logic [3:0] r_win_cnt, n_win_cnt;
    logic [2:0] r_hold_cnt, n_hold_cnt;
    logic [2:0] r_idx, n_idx;
    logic [7:0] r_win [WIN_DEPTH];
    logic [7:0] n_win [WIN_DEPTH];
    logic [7:0] r_hold [HOLD_DEPTH];
    logic [7:0] n_hold [HOLD_DEPTH];
    logic [7:0] r_c;
    logic       r_last;

    logic [8*WIN_DEPTH-1:0] w_win_flat;
    logic [7:0]             w_cand [CAND_LEN];
    logic                   w_ok;
    logic                   w_ent_hit;
    logic                   w_ent_done;
    logic [7:0]             w_ent_dec;
    logic                   w_win_app;
    logic                   w_do_norm;
    logic                   w_finish;
    logic                   w_ready;
    logic                   w_adv;
    logic                   w_acc;
    logic                   w_push;
    hte_pkg::t_evt          w_evt;

    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            w_win_flat[8*(WIN_DEPTH-1-i) +: 8] = r_win[i];
        end
    end

    // Held bytes plus the new word, checked against every entity
    always_comb begin
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            w_cand[i] = (3'(i) < r_hold_cnt) ? r_hold[i] : r_c;
        end
        w_cand[HOLD_DEPTH] = r_c;
        w_ent_hit  = 1'b0;
        w_ent_done = 1'b0;
        w_ent_dec  = hte_pkg::CH_NUL;
        w_ok       = 1'b0;
        for (int e = 0; e < NUM_ENT; e++) begin
            w_ok = (r_hold_cnt < ENT_LEN[e]);
            for (int i = 0; i < CAND_LEN; i++) begin
                if (3'(i) <= r_hold_cnt && w_cand[i] != ENT_TXT[e][47-8*i -: 8]) begin
                    w_ok = 1'b0;
                end
            end
            if (w_ok && !w_ent_hit) begin
                w_ent_hit  = 1'b1;
                w_ent_done = ((r_hold_cnt + 3'd1) == ENT_LEN[e]);
                w_ent_dec  = ENT_DEC[e];
            end
        end
    end

    assign w_win_app = (r_win_cnt != 4'd0) && (r_win_cnt < WIN_FULL);

    always_comb begin
        n_state     = r_state;
        n_in_tag    = r_in_tag;
        n_scr_body  = r_scr_body;
        n_sty_body  = r_sty_body;
        n_win_cnt   = r_win_cnt;
        n_hold_cnt  = r_hold_cnt;
        n_idx       = r_idx;
        n_win       = r_win;
        n_hold      = r_hold;
        w_push      = 1'b0;
        w_evt       = '{data: hte_pkg::CH_NUL, is_end: 1'b0, from_last: r_last};
        w_ready     = 1'b0;
        w_do_norm   = 1'b0;
        w_finish    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                w_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_hold_cnt != 3'd0) begin
                    if (w_ent_hit) begin
                        if (w_ent_done) begin
                            w_push      = 1'b1;
                            w_evt.data  = w_ent_dec;
                            n_hold_cnt  = 3'd0;
                        end else begin
                            n_hold[r_hold_cnt] = r_c;
                            n_hold_cnt         = r_hold_cnt + 3'd1;
                        end
                        w_finish = 1'b1;
                    end else begin
                        // broken entity: replay the held words first
                        n_state = ST_FLUSH;
                        n_idx   = 3'd0;
                    end
                end else begin
                    w_do_norm = 1'b1;
                    w_finish  = 1'b1;
                end
            end
            ST_NORM: begin
                w_do_norm = 1'b1;
                w_finish  = 1'b1;
            end
            ST_FLUSH, ST_LFLUSH: begin
                w_push     = 1'b1;
                w_evt.data = r_hold[r_idx];
                if (r_idx == r_hold_cnt - 3'd1) begin
                    n_hold_cnt = 3'd0;
                    n_state    = (r_state == ST_FLUSH) ? ST_NORM : ST_END;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            ST_END: begin
                if (r_hold_cnt != 3'd0) begin
                    n_state = ST_LFLUSH;
                    n_idx   = 3'd0;
                end else begin
                    // mark end of document and return to reset state
                    w_push       = 1'b1;
                    w_evt.is_end = 1'b1;
                    n_in_tag     = 1'b0;
                    n_scr_body   = 1'b0;
                    n_sty_body   = 1'b0;
                    n_win_cnt    = 4'd0;
                    n_hold_cnt   = 3'd0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_do_norm) begin
            if (r_c == hte_pkg::CH_LT) begin
                n_win[0]  = hte_pkg::CH_LT;
                n_win_cnt = 4'd1;
                n_in_tag  = 1'b1;
            end else if (r_c == hte_pkg::CH_GT) begin
                n_in_tag = 1'b0;
                if (r_scr_body) begin
                    if (r_win_cnt == CLOSE_SCRIPT_LEN &&
                        (w_win_flat[8*WIN_DEPTH-1 -: 64] == CLOSE_SCRIPT_LC ||
                         w_win_flat[8*WIN_DEPTH-1 -: 64] == CLOSE_SCRIPT_UC)) begin
                        n_scr_body = 1'b0;
                    end
                end else if (r_sty_body) begin
                    if (r_win_cnt == CLOSE_STYLE_LEN &&
                        (w_win_flat[8*WIN_DEPTH-1 -: 56] == CLOSE_STYLE_LC ||
                         w_win_flat[8*WIN_DEPTH-1 -: 56] == CLOSE_STYLE_UC)) begin
                        n_sty_body = 1'b0;
                    end
                end
                if (w_win_app) begin
                    n_win[r_win_cnt] = r_c;
                    n_win_cnt        = r_win_cnt + 4'd1;
                end
            end else begin
                if (w_win_app) begin
                    n_win[r_win_cnt] = r_c;
                    n_win_cnt        = r_win_cnt + 4'd1;
                end
                // window reads a full opening name once this word lands
                if (r_win_cnt == OPEN_SCRIP_LEN &&
                    ((r_c == CH_T_LC && w_win_flat[8*WIN_DEPTH-1 -: 48] == OPEN_SCRIP_LC) ||
                     (r_c == CH_T_UC && w_win_flat[8*WIN_DEPTH-1 -: 48] == OPEN_SCRIP_UC)))
                begin
                    n_scr_body = 1'b1;
                end else if (r_win_cnt == OPEN_STYL_LEN &&
                    ((r_c == CH_E_LC && w_win_flat[8*WIN_DEPTH-1 -: 40] == OPEN_STYL_LC) ||
                     (r_c == CH_E_UC && w_win_flat[8*WIN_DEPTH-1 -: 40] == OPEN_STYL_UC)))
                begin
                    n_sty_body = 1'b1;
                end
                if (!(n_scr_body || n_sty_body || r_in_tag)) begin
                    if (r_c == hte_pkg::CH_AMP) begin
                        n_hold[0]  = hte_pkg::CH_AMP;
                        n_hold_cnt = 3'd1;
                    end else begin
                        w_push     = 1'b1;
                        w_evt.data = r_c;
                    end
                end
            end
        end

        // take the next word in the same cycle this one finishes, unless it is the final word or its push stalls
        if (w_finish) begin
            if (r_last) begin
                n_state = ST_END;
            end else begin
                w_ready = !w_push || !i_full;
                n_state = (w_ready && i_in_valid) ? ST_EVAL : ST_IDLE;
            end
        end
    end

    assign w_adv      = !w_push || !i_full;
    assign w_acc      = i_in_valid && w_ready;
    assign o_in_ready = w_ready;
    assign o_push     = w_push && !i_full;
    assign o_evt      = w_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_tag    <= 1'b0;
            r_scr_body  <= 1'b0;
            r_sty_body  <= 1'b0;
            r_win_cnt   <= 4'd0;
            r_hold_cnt  <= 3'd0;
            r_idx       <= 3'd0;
        end else if (w_adv) begin
            r_state     <= n_state;
            r_in_tag    <= n_in_tag;
            r_scr_body  <= n_scr_body;
            r_sty_body  <= n_sty_body;
            r_win_cnt   <= n_win_cnt;
            r_hold_cnt  <= n_hold_cnt;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_win  <= n_win;
            r_hold <= n_hold;
        end
        if (w_acc) begin
            r_c    <= i_in_byte;
            r_last <= i_in_last;
        end
    end

    `HTE_ASSERT(a_flush_has_hold, i_clk, i_rst_n, (r_state == ST_FLUSH || r_state == ST_LFLUSH) |-> (r_hold_cnt != 3'd0 && r_idx < r_hold_cnt), "flush with no held word")
    `HTE_ASSERT(a_counts_bounded, i_clk, i_rst_n, (r_win_cnt <= WIN_FULL) && (r_hold_cnt <= 3'(HOLD_DEPTH)), "window or hold count out of range")
    `HTE_ASSERT(a_accept_evals, i_clk, i_rst_n, w_acc |=> (r_state == ST_EVAL), "accepted word not evaluated")

endmodule

FILE: design/hte_fifo.sv
// ----------------------------------------------------------------------------
// hte_fifo
// Short event queue that decouples the classifying front from the output back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hte_fifo #(
    parameter int DEPTH = hte_pkg::FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hte_pkg::t_evt i_evt,
    output logic          o_full,
    input  logic          i_pop,
    output hte_pkg::t_evt o_evt,
    output logic          o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hte_pkg::t_evt    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_evt   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    `HTE_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `HTE_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")
    `HTE_ASSERT(a_ptr_in_range, i_clk, i_rst_n, (r_wr <= PTR_W'(DEPTH - 1)) && (r_rd <= PTR_W'(DEPTH - 1)), "queue pointer out of range")

endmodule

FILE: design/hte_back.sv
// ----------------------------------------------------------------------------
// hte_back
// Collapses whitespace runs, stages one text word so the final word of a
// document can carry the last flag, and drives the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hte_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hte_pkg::t_evt i_evt,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_out_has_byte,
    output logic          o_out_last
);

    logic       r_stg_v, n_stg_v;
    logic [7:0] r_stg_byte, n_stg_byte;
    logic       r_stg_fin, n_stg_fin;
    logic       r_last_space, n_last_space;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_has_byte, n_out_has_byte;
    logic       r_out_last, n_out_last;
    logic       w_ws;
    logic       w_out_free;
    logic       w_load;

    always_comb begin
        w_ws = i_evt.data inside {hte_pkg::CH_SPACE, [hte_pkg::CH_TAB:hte_pkg::CH_CR]};
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_stg_v        = r_stg_v;
        n_stg_byte     = r_stg_byte;
        n_stg_fin      = r_stg_fin;
        n_last_space   = r_last_space;
        n_out_byte     = r_out_byte;
        n_out_has_byte = r_out_has_byte;
        n_out_last     = r_out_last;
        o_pop          = 1'b0;
        w_load         = 1'b0;

        if (!i_empty) begin
            if (i_evt.is_end) begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    if (r_stg_v && !r_stg_fin) begin
                        // staged word predates the final word: send it plain, keep the marker
                        n_out_byte     = r_stg_byte;
                        n_out_has_byte = 1'b1;
                        n_out_last     = 1'b0;
                        n_stg_v        = 1'b0;
                    end else begin
                        // close the document on the staged word, or a bare marker
                        o_pop          = 1'b1;
                        n_out_byte     = r_stg_v ? r_stg_byte : hte_pkg::CH_NUL;
                        n_out_has_byte = r_stg_v;
                        n_out_last     = 1'b1;
                        n_stg_v        = 1'b0;
                        n_last_space   = 1'b0;
                    end
                end
            end else if (w_ws && r_last_space) begin
                o_pop = 1'b1;
            end else if (!r_stg_v) begin
                o_pop        = 1'b1;
                n_stg_v      = 1'b1;
                n_stg_byte   = w_ws ? hte_pkg::CH_SPACE : i_evt.data;
                n_stg_fin    = i_evt.from_last;
                n_last_space = w_ws;
            end else if (w_out_free) begin
                o_pop          = 1'b1;
                w_load         = 1'b1;
                n_out_byte     = r_stg_byte;
                n_out_has_byte = 1'b1;
                n_out_last     = 1'b0;
                n_stg_byte     = w_ws ? hte_pkg::CH_SPACE : i_evt.data;
                n_stg_fin      = i_evt.from_last;
                n_last_space   = w_ws;
            end
        end

        n_out_valid = w_load || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_v      <= 1'b0;
            r_last_space <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_stg_v      <= n_stg_v;
            r_last_space <= n_last_space;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stg_byte     <= n_stg_byte;
        r_stg_fin      <= n_stg_fin;
        r_out_byte     <= n_out_byte;
        r_out_has_byte <= n_out_has_byte;
        r_out_last     <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_out_has_byte = r_out_has_byte;
    assign o_out_last     = r_out_last;

    `HTE_ASSERT(a_end_closes, i_clk, i_rst_n, (o_pop && i_evt.is_end) |=> (r_out_valid && r_out_last && !r_stg_v && !r_last_space), "end marker did not close document")
    `HTE_ASSERT(a_empty_is_last, i_clk, i_rst_n, (r_out_valid && !r_out_has_byte) |-> r_out_last, "empty word without last flag")

endmodule

FILE: design/html_text_extractor.sv
// ----------------------------------------------------------------------------
// html_text_extractor
// Streams HTML words in and visible text words out.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid/o_in_ready carry one HTML word (i_in_byte) and
// i_in_last, which marks the final word of a document. Output channel:
// o_out_valid/i_out_ready carry o_out_byte, o_out_has_byte and o_out_last.
// Tags, script and style bodies are dropped, the five common entities are
// decoded and whitespace runs collapse to one space.
// Throughput: one word per cycle on plain text and tags while the queue
// has room, set by the front sequencer's evaluate step; the first word
// after idle also passes the idle step. A broken entity adds a replay of
// each held word and a step for the breaking word. A final word adds an
// end step, after a replay of the held words when an entity is still open.
// Flow: a text word is registered in the front, pushed into the queue and
// staged in the back until the next text word or the end of the document
// arrives, so the last word can carry o_out_last. When the final word yields
// no text, the document ends in one word with o_out_has_byte low.
// Reset clears all tag, entity and whitespace state and empties the queue.
// When the receiver stalls, the output register holds, the back stops
// draining the queue, and o_in_ready drops when a push meets a full queue.
// ----------------------------------------------------------------------------

module html_text_extractor #(
    parameter int FIFO_DEPTH = hte_pkg::FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_has_byte,
    output logic       o_out_last
);

    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_empty;
    hte_pkg::t_evt w_evt_in;
    hte_pkg::t_evt w_evt_out;

    hte_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_push     (w_push),
        .o_evt      (w_evt_in),
        .i_full     (w_full)
    );

    hte_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_evt   (w_evt_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_evt   (w_evt_out),
        .o_empty (w_empty)
    );

    hte_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_evt          (w_evt_out),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_out_has_byte (o_out_has_byte),
        .o_out_last     (o_out_last)
    );

endmodule

FILE: tb/sv/html_text_checker.sv
// ----------------------------------------------------------------------------
// html_text_checker
// Watches both channels of the text extractor, predicts the visible text
// words of every accepted HTML word and compares them in order.
// ----------------------------------------------------------------------------
module html_text_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_has_byte,
    input  logic       i_out_last,
    output int         o_mismatch_cnt,
    output int         o_pending_cnt
);
    import hte_pkg::*;

    localparam int         WIN_LEN   = 9;
    localparam int         HOLD_LEN  = 5;
    localparam int         NUM_ENT   = 5;
    localparam int         MAX_WORDS = 7;
    localparam int         SHOWN     = 10;
    localparam logic [7:0] CH_QUOT   = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } text_word_t;

    // parser state
    logic       in_tag;
    logic       scr_on;
    logic       sty_on;
    logic [7:0] tag_win [WIN_LEN];
    int         tag_cnt;
    logic [7:0] ent_buf [HOLD_LEN];
    int         ent_cnt;
    logic       sp_last;

    text_word_t step_buf [MAX_WORDS];
    int         step_n;
    text_word_t text_q [$];
    text_word_t want;
    int         miss_n = 0;

    function automatic string ent_text(input int e);
        case (e)
            0:       return "&amp;";
            1:       return "&lt;";
            2:       return "&gt;";
            3:       return "&quot;";
            default: return "&#39;";
        endcase
    endfunction

    function automatic logic [7:0] ent_char(input int e);
        case (e)
            0:       return CH_AMP;
            1:       return CH_LT;
            2:       return CH_GT;
            3:       return CH_QUOT;
            default: return CH_APOS;
        endcase
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void clear_state();
        int i;
        in_tag    = 1'b0;
        scr_on    = 1'b0;
        sty_on    = 1'b0;
        tag_cnt   = 0;
        ent_cnt   = 0;
        sp_last   = 1'b0;
        for (i = 0; i < WIN_LEN; i++) tag_win[i] = CH_NUL;
        for (i = 0; i < HOLD_LEN; i++) ent_buf[i] = CH_NUL;
    endfunction

    function automatic void put_word(input logic [7:0] b, input logic has);
        if (step_n < MAX_WORDS) begin
            step_buf[step_n] = '{data: b, has: has, last: 1'b0};
            step_n++;
        end
    endfunction

    // collapse whitespace runs into one space
    function automatic void emit_char(input logic [7:0] c);
        if (is_space(c)) begin
            if (!sp_last) put_word(CH_SPACE, 1'b1);
            sp_last = 1'b1;
        end else begin
            put_word(c, 1'b1);
            sp_last = 1'b0;
        end
    endfunction

    function automatic bit win_is(input string s);
        int i;
        if (tag_cnt != s.len()) return 1'b0;
        for (i = 0; i < tag_cnt; i++) begin
            if (tag_win[i] != s[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void win_add(input logic [7:0] c);
        if (tag_cnt > 0 && tag_cnt < WIN_LEN) begin
            tag_win[tag_cnt] = c;
            tag_cnt++;
        end
    endfunction

    function automatic void flush_ent();
        int i;
        for (i = 0; i < ent_cnt; i++) emit_char(ent_buf[i]);
        ent_cnt = 0;
    endfunction

    // extend the held entity, or release it as text when c breaks it
    function automatic bit hold_takes(input logic [7:0] c);
        int    m;
        int    e;
        int    k;
        string nm;
        bit    ok;
        if (ent_cnt == 0) return 1'b0;
        m = ent_cnt + 1;
        for (e = 0; e < NUM_ENT; e++) begin
            nm = ent_text(e);
            if (m <= nm.len()) begin
                ok = (nm[m-1] == c);
                for (k = 0; k < m - 1; k++) begin
                    if (ent_buf[k] != nm[k]) ok = 1'b0;
                end
                if (ok) begin
                    if (m == nm.len()) begin
                        ent_cnt = 0;
                        emit_char(ent_char(e));
                    end else begin
                        ent_buf[m-1] = c;
                        ent_cnt      = m;
                    end
                    return 1'b1;
                end
            end
        end
        flush_ent();
        return 1'b0;
    endfunction

    function automatic void take_byte(input logic [7:0] c);
        if (hold_takes(c)) return;
        if (c == CH_LT) begin
            tag_win[0] = CH_LT;
            tag_cnt    = 1;
            in_tag     = 1'b1;
            return;
        end
        if (c == CH_GT) begin
            in_tag = 1'b0;
            if (scr_on) begin
                if (win_is("</script") || win_is("</SCRIPT")) scr_on = 1'b0;
            end else if (sty_on) begin
                if (win_is("</style") || win_is("</STYLE")) sty_on = 1'b0;
            end
            win_add(c);
            return;
        end
        win_add(c);
        if (win_is("<script") || win_is("<SCRIPT")) scr_on = 1'b1;
        else if (win_is("<style") || win_is("<STYLE")) sty_on = 1'b1;
        if (scr_on || sty_on || in_tag) return;
        if (c == CH_AMP) begin
            ent_buf[0] = CH_AMP;
            ent_cnt    = 1;
            return;
        end
        emit_char(c);
    endfunction

    function automatic void predict_text(input logic [7:0] c, input logic last);
        int i;
        step_n = 0;
        take_byte(c);
        if (last) begin
            flush_ent();
            if (step_n == 0) put_word(CH_NUL, 1'b0);
            step_buf[step_n-1].last = 1'b1;
            clear_state();
        end
        for (i = 0; i < step_n; i++) text_q.push_back(step_buf[i]);
    endfunction

    function automatic void note_miss(input string what);
        miss_n++;
        if (miss_n <= SHOWN) begin
            $display("%m: %s: expected %02h/%0b/%0b, got %02h/%0b/%0b", what,
                     want.data, want.has, want.last,
                     i_out_byte, i_out_has_byte, i_out_last);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            text_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) predict_text(i_in_byte, i_in_last);
            if (i_out_valid && i_out_ready) begin
                if (text_q.size() == 0) begin
                    want = '0;
                    note_miss("word with nothing pending");
                end else begin
                    want = text_q.pop_front();
                    if (want.data !== i_out_byte || want.has !== i_out_has_byte ||
                        want.last !== i_out_last) begin
                        note_miss("text word mismatch");
                    end
                end
            end
        end
        o_pending_cnt  <= text_q.size();
        o_mismatch_cnt <= miss_n;
    end

endmodule

FILE: tb/sv/tb_html_text_extractor.sv
// ----------------------------------------------------------------------------
// tb_html_text_extractor
// Feeds HTML documents to the text extractor: a few hand-picked ones, then
// random documents built from text, entities, tags and script/style blocks,
// under four mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_html_text_extractor;
    import hte_pkg::*;

    localparam int BYTES_PER_PHASE = 72;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 40;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       out_has_byte;
    logic       out_last;

    int         src_idle_pct  = 0;
    int         snk_stall_pct = 0;
    int         quiet_cycles  = 0;
    int         mismatch_cnt;
    int         pending_cnt;
    logic [7:0] doc_q [$];

    always #10 clk = ~clk;

    html_text_extractor u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_in_byte      (in_byte),
        .i_in_last      (in_last),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_out_byte     (out_byte),
        .o_out_has_byte (out_has_byte),
        .o_out_last     (out_last)
    );

    html_text_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_byte      (in_byte),
        .i_in_last      (in_last),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_byte     (out_byte),
        .i_out_has_byte (out_has_byte),
        .i_out_last     (out_last),
        .o_mismatch_cnt (mismatch_cnt),
        .o_pending_cnt  (pending_cnt)
    );

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_html_text_extractor: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] text_char();
        case ($urandom_range(9))
            0, 1, 2: return 8'h61 + 8'($urandom_range(25));  // lower case
            3:       return 8'h41 + 8'($urandom_range(25));  // upper case
            4:       return CH_SPACE;
            5:       return CH_TAB + 8'($urandom_range(4));
            6:       return 8'($urandom_range(255));
            7:       return CH_AMP;
            8:       return 8'h80 + 8'($urandom_range(127));
            default: return 8'h21 + 8'($urandom_range(30));
        endcase
    endfunction

    function automatic void add_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
    endfunction

    function automatic string entity_name(input int k);
        case (k)
            0:       return "&amp;";
            1:       return "&lt;";
            2:       return "&gt;";
            3:       return "&quot;";
            default: return "&#39;";
        endcase
    endfunction

    function automatic string raw_name(input int k);
        case (k)
            0:       return "script";
            1:       return "SCRIPT";
            2:       return "style";
            3:       return "STYLE";
            4:       return "Script";
            default: return "stYLE";
        endcase
    endfunction

    // whole entity, broken prefix, or a prefix left open
    function automatic void add_entity();
        string nm;
        int    cut;
        int    i;
        nm = entity_name($urandom_range(4));
        if ($urandom_range(2) != 0) begin
            add_str(nm);
        end else begin
            cut = $urandom_range(1, nm.len() - 1);
            for (i = 0; i < cut; i++) doc_q.push_back(nm[i]);
            case ($urandom_range(5))
                0:       doc_q.push_back(CH_LT);
                1:       doc_q.push_back(CH_SPACE);
                2:       doc_q.push_back(CH_AMP);
                3:       doc_q.push_back(8'($urandom_range(255)));
                4:       doc_q.push_back(text_char());
                default: ;
            endcase
        end
    endfunction

    function automatic void add_tag();
        int n;
        int i;
        doc_q.push_back(CH_LT);
        if ($urandom_range(2) == 0) add_str("/");
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) doc_q.push_back(8'h61 + 8'($urandom_range(25)));
        if ($urandom_range(2) == 0) add_str(" k=\"v&x\"");
        doc_q.push_back(CH_GT);
    endfunction

    // script or style body, closed mostly by the matching tag
    function automatic void add_raw_block();
        int k;
        int n;
        int i;
        k = $urandom_range(5);
        add_str({"<", raw_name(k)});
        if ($urandom_range(3) == 0) add_str(" a=1");
        doc_q.push_back(CH_GT);
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++) doc_q.push_back(text_char());
        if ($urandom_range(3) == 0) add_str("<b>x&lt;</p>");
        case ($urandom_range(9))
            0, 1:    add_str({"</", raw_name($urandom_range(5)), ">"});
            2:       ;
            default: add_str({"</", raw_name(k), ">"});
        endcase
    endfunction

    function automatic void build_doc();
        int target;
        int n;
        int i;
        doc_q.delete();
        target = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(6, 40);
        while (doc_q.size() < target) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++) doc_q.push_back(text_char());
                end
                3, 4:    add_entity();
                5, 6:    add_tag();
                7:       add_raw_block();
                8:       doc_q.push_back(CH_GT);
                default: begin
                    n = $urandom_range(1, 3);
                    for (i = 0; i < n; i++) doc_q.push_back(CH_TAB + 8'($urandom_range(4)));
                end
            endcase
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        // ready is stable by the falling edge, so the next rising edge takes the word
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    task automatic send_doc();
        int i;
        for (i = 0; i < doc_q.size(); i++) send_byte(doc_q[i], i == doc_q.size() - 1);
    endtask

    initial begin
        int phase;
        int sent;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_byte   = CH_NUL;
        in_last   = 1'b0;
        out_ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // empty document, stray close, high and low bytes, whitespace run,
        // entity open at the end, entity broken by a tag
        send_byte(CH_LT, 1'b1);
        doc_q.delete();
        add_str(">x");
        send_doc();
        doc_q.delete();
        doc_q.push_back(8'hFF);
        add_str(" \t\n");
        doc_q.push_back(CH_NUL);
        add_str("&lt");
        send_doc();
        doc_q.delete();
        add_str("&am<b>&#39;");
        send_doc();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 51; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 51; end
                default: begin src_idle_pct = 30; snk_stall_pct = 30; end
            endcase
            sent = 0;
            while (sent < BYTES_PER_PHASE) begin
                build_doc();
                send_doc();
                sent += doc_q.size();
            end
        end
        in_valid <= 1'b0;

        @(negedge clk);
        while (pending_cnt != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_cnt == 0) begin
            $display("tb_html_text_extractor: done, clean");
        end else begin
            $display("tb_html_text_extractor: done, errors");
        end
        $finish;
    end

endmodule
